@@ design/qkve_pkg.sv @@
// Shared types and constants of the query key/value extractor.
package qkve_pkg;

    localparam int QKVE_MAX_KEY   = 24;  // longest key the match chain can hold
    localparam int QKVE_MAX_VALUE = 29;  // value bytes kept per string
    localparam int QKVE_KEY_SLOTS = 24;  // key characters held in the key registers
    localparam int QKVE_ADDR_W    = 5;   // byte address, 64-bit registers at 8*i
    localparam int QKVE_DATA_W    = 64;

    localparam logic [7:0] QKVE_CH_AMP  = 8'h26;  // '&'
    localparam logic [7:0] QKVE_CH_QRY  = 8'h3F;  // '?'
    localparam logic [7:0] QKVE_CH_EQ   = 8'h3D;  // '='
    localparam logic [7:0] QKVE_CH_SEMI = 8'h3B;  // ';'
    localparam logic [7:0] QKVE_CH_LF   = 8'h0A;  // newline
    localparam logic [7:0] QKVE_CH_NUL  = 8'h00;

    typedef enum logic [1:0] {
        REG_KEY_LENGTH = 2'd0,
        REG_KEY_LOW    = 2'd1,
        REG_KEY_MID    = 2'd2,
        REG_KEY_HIGH   = 2'd3
    } t_reg_idx;

    typedef enum logic {
        ST_SCAN = 1'b0,
        ST_EMIT = 1'b1
    } t_state;

    // partial-match status of both pattern forms
    typedef struct packed {
        logic amp;
        logic qry;
    } t_lane;

endpackage

@@ design/qkve_match_cell.sv @@
// One cell of the pattern match chain: compares the incoming byte and extends the neighbor's run.
module qkve_match_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_shift,
    input  logic                i_clear,
    input  logic [7:0]          i_byte,
    input  logic [7:0]          i_exp_amp,
    input  logic [7:0]          i_exp_qry,
    input  qkve_pkg::t_lane     i_prev,
    output qkve_pkg::t_lane     o_hit,
    output qkve_pkg::t_lane     o_run
);

    qkve_pkg::t_lane r_run;

    // pattern prefix through this cell ends at the current byte
    assign o_hit.amp = i_prev.amp && (i_byte == i_exp_amp);
    assign o_hit.qry = i_prev.qry && (i_byte == i_exp_qry);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_run <= '0;
        end else if (i_shift) begin
            r_run <= o_hit;
        end
    end

    assign o_run = r_run;

endmodule

@@ design/qkve_value_cell.sv @@
// One cell of the value buffer chain: loaded during capture, shifts toward the head on emission.
module qkve_value_cell (
    input  logic       i_clk,
    input  logic       i_write,
    input  logic [7:0] i_wr_byte,
    input  logic       i_shift,
    input  logic [7:0] i_next,
    output logic [7:0] o_byte
);

    logic [7:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (i_write) begin
            r_byte <= i_wr_byte;
        end else if (i_shift) begin
            r_byte <= i_next;
        end
    end

    assign o_byte = r_byte;

endmodule

@@ design/query_key_value_extractor_top.sv @@
// Top level of the query key/value extractor: config port, match chain, value chain, control.
// Input: a byte that does not end the string is absorbed at 1 byte per cycle while in scan.
// On the end-of-string byte the first result appears the next cycle; N value bytes
// leave at one per cycle while the receiver is ready (one result if empty), input held off meanwhile.
// Reset (synchronous, active low) clears control, match chain and key registers;
// the value buffer is not cleared and no clearing pass is run.
module query_key_value_extractor_top #(
    parameter int MAX_KEY   = qkve_pkg::QKVE_MAX_KEY,
    parameter int MAX_VALUE = qkve_pkg::QKVE_MAX_VALUE
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input channel
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic [7:0]                      i_data_byte,
    input  logic                            i_end_of_string,
    // result channel
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic [7:0]                      o_value_byte,
    output logic                            o_key_found,
    output logic                            o_from_query_form,
    output logic                            o_value_empty,
    output logic                            o_value_truncated,
    output logic                            o_last_of_value,
    // configuration port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [qkve_pkg::QKVE_ADDR_W-1:0] paddr,
    input  logic [qkve_pkg::QKVE_DATA_W-1:0] pwdata,
    output logic [qkve_pkg::QKVE_DATA_W-1:0] prdata,
    output logic                            pready
);

    localparam int LW = $clog2(MAX_KEY + 2);     // indexes cells 0..MAX_KEY+1
    localparam int VW = $clog2(MAX_VALUE + 1);   // value count 0..MAX_VALUE

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [4:0]  r_key_length;
    logic [63:0] r_key_low;
    logic [63:0] r_key_mid;
    logic [63:0] r_key_high;

    logic              w_cfg_wr;
    qkve_pkg::t_reg_idx w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite;
    assign w_cfg_idx = qkve_pkg::t_reg_idx'(paddr[4:3]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_length <= 5'd1;
            r_key_low    <= '0;
            r_key_mid    <= '0;
            r_key_high   <= '0;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                qkve_pkg::REG_KEY_LENGTH: r_key_length <= pwdata[4:0];
                qkve_pkg::REG_KEY_LOW:    r_key_low    <= pwdata;
                qkve_pkg::REG_KEY_MID:    r_key_mid    <= pwdata;
                qkve_pkg::REG_KEY_HIGH:   r_key_high   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            qkve_pkg::REG_KEY_LENGTH: prdata = {59'd0, r_key_length};
            qkve_pkg::REG_KEY_LOW:    prdata = r_key_low;
            qkve_pkg::REG_KEY_MID:    prdata = r_key_mid;
            qkve_pkg::REG_KEY_HIGH:   prdata = r_key_high;
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    qkve_pkg::t_state r_state, n_state;
    logic [VW-1:0]    r_left, n_left;      // results still to send
    logic [VW-1:0]    r_count, n_count;    // bytes captured so far
    logic             r_capt, n_capt;
    logic             r_amp, n_amp;        // '&' form seen
    logic             r_qry, n_qry;        // '?' form seen
    logic             r_trunc, n_trunc;
    logic             r_ended, n_ended;    // zero byte seen

    logic w_acc_in, w_acc_out, w_last, w_clear, w_shift_val, w_live, w_store_wr;

    assign o_in_ready  = (r_state == qkve_pkg::ST_SCAN);
    assign o_out_valid = (r_state == qkve_pkg::ST_EMIT);
    assign w_acc_in    = i_in_valid && o_in_ready;
    assign w_acc_out   = o_out_valid && i_out_ready;
    assign w_last      = (r_left <= VW'(1));
    // a byte that advances the match chain
    assign w_live      = w_acc_in && !r_ended && (i_data_byte != qkve_pkg::QKVE_CH_NUL);

    // ------------------------------------------------------------------
    // Match chain: cell 0 checks the prefix, cell k (1..len) key char k-1,
    // cell len+1 the '='. A hit out of cell len+1 is a full pattern.
    // ------------------------------------------------------------------
    logic [LW-1:0]   w_len, w_len_p1;
    logic [191:0]    w_key_flat;
    qkve_pkg::t_lane w_hit [0:MAX_KEY+1];
    qkve_pkg::t_lane w_run [0:MAX_KEY];
    qkve_pkg::t_lane w_match;

    assign w_len      = (32'(r_key_length) > MAX_KEY) ? LW'(MAX_KEY) : LW'(r_key_length);
    assign w_len_p1   = w_len + LW'(1);
    assign w_key_flat = {r_key_high, r_key_mid, r_key_low};
    assign w_match    = w_hit[w_len_p1];

    qkve_match_cell u_prefix_cell (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_shift   (w_live),
        .i_clear   (w_clear),
        .i_byte    (i_data_byte),
        .i_exp_amp (qkve_pkg::QKVE_CH_AMP),
        .i_exp_qry (qkve_pkg::QKVE_CH_QRY),
        .i_prev    ('{amp: 1'b1, qry: 1'b1}),
        .o_hit     (w_hit[0]),
        .o_run     (w_run[0])
    );

    for (genvar k = 1; k <= MAX_KEY + 1; k++) begin : g_match
        logic [7:0] w_key_c;
        logic [7:0] w_exp;

        // key characters past the key registers read as zero
        if (k - 1 < qkve_pkg::QKVE_KEY_SLOTS) begin : g_key
            assign w_key_c = w_key_flat[(k-1)*8 +: 8];
        end else begin : g_nokey
            assign w_key_c = qkve_pkg::QKVE_CH_NUL;
        end

        assign w_exp = (LW'(k) <= w_len) ? w_key_c : qkve_pkg::QKVE_CH_EQ;

        if (k <= MAX_KEY) begin : g_mid
            qkve_match_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_shift   (w_live),
                .i_clear   (w_clear),
                .i_byte    (i_data_byte),
                .i_exp_amp (w_exp),
                .i_exp_qry (w_exp),
                .i_prev    (w_run[k-1]),
                .o_hit     (w_hit[k]),
                .o_run     (w_run[k])
            );
        end else begin : g_tail
            // last cell only ever terminates a pattern; its run is never extended
            qkve_match_cell u_cell (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_shift   (w_live),
                .i_clear   (w_clear),
                .i_byte    (i_data_byte),
                .i_exp_amp (w_exp),
                .i_exp_qry (w_exp),
                .i_prev    (w_run[k-1]),
                .o_hit     (w_hit[k]),
                .o_run     ()
            );
        end
    end

    // ------------------------------------------------------------------
    // Capture control
    // ------------------------------------------------------------------
    logic w_term;
    assign w_term = (i_data_byte == qkve_pkg::QKVE_CH_AMP) ||
                    (i_data_byte == qkve_pkg::QKVE_CH_SEMI) ||
                    (i_data_byte == qkve_pkg::QKVE_CH_LF);

    always_comb begin
        n_count    = r_count;
        n_capt     = r_capt;
        n_amp      = r_amp;
        n_qry      = r_qry;
        n_trunc    = r_trunc;
        n_ended    = r_ended;
        w_store_wr = 1'b0;
        if (w_acc_in && !r_ended) begin
            if (i_data_byte == qkve_pkg::QKVE_CH_NUL) begin
                n_ended = 1'b1;
                n_capt  = 1'b0;
            end else begin
                if (r_capt) begin
                    if (w_term) begin
                        n_capt = 1'b0;
                    end else if (r_count >= VW'(MAX_VALUE)) begin
                        n_capt  = 1'b0;
                        n_trunc = 1'b1;
                    end else begin
                        w_store_wr = 1'b1;
                        n_count    = r_count + VW'(1);
                    end
                end
                // '&' form wins over a running or finished '?' capture
                if (!r_amp && w_match.amp) begin
                    n_amp   = 1'b1;
                    n_capt  = 1'b1;
                    n_count = '0;
                    n_trunc = 1'b0;
                end else if (!r_amp && !r_qry && w_match.qry) begin
                    n_qry   = 1'b1;
                    n_capt  = 1'b1;
                    n_count = '0;
                    n_trunc = 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Scan / emit sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        w_clear     = 1'b0;
        w_shift_val = 1'b0;
        unique case (r_state)
            qkve_pkg::ST_SCAN: begin
                if (w_acc_in && i_end_of_string) begin
                    n_state = qkve_pkg::ST_EMIT;
                    n_left  = n_count;
                end
            end
            qkve_pkg::ST_EMIT: begin
                if (w_acc_out) begin
                    if (w_last) begin
                        n_state = qkve_pkg::ST_SCAN;
                        w_clear = 1'b1;
                    end else begin
                        n_left      = r_left - VW'(1);
                        w_shift_val = 1'b1;
                    end
                end
            end
            default: n_state = qkve_pkg::ST_SCAN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= qkve_pkg::ST_SCAN;
            r_left  <= '0;
            r_count <= '0;
            r_capt  <= 1'b0;
            r_amp   <= 1'b0;
            r_qry   <= 1'b0;
            r_trunc <= 1'b0;
            r_ended <= 1'b0;
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            if (w_clear) begin
                r_count <= '0;
                r_capt  <= 1'b0;
                r_amp   <= 1'b0;
                r_qry   <= 1'b0;
                r_trunc <= 1'b0;
                r_ended <= 1'b0;
            end else begin
                r_count <= n_count;
                r_capt  <= n_capt;
                r_amp   <= n_amp;
                r_qry   <= n_qry;
                r_trunc <= n_trunc;
                r_ended <= n_ended;
            end
        end
    end

    // ------------------------------------------------------------------
    // Value chain: written at the capture count, drained from cell 0
    // ------------------------------------------------------------------
    logic [7:0] w_val [0:MAX_VALUE];

    assign w_val[MAX_VALUE] = qkve_pkg::QKVE_CH_NUL;

    for (genvar j = 0; j < MAX_VALUE; j++) begin : g_value
        qkve_value_cell u_vcell (
            .i_clk     (i_clk),
            .i_write   (w_store_wr && (r_count == VW'(j))),
            .i_wr_byte (i_data_byte),
            .i_shift   (w_shift_val),
            .i_next    (w_val[j+1]),
            .o_byte    (w_val[j])
        );
    end

    // ------------------------------------------------------------------
    // Result payload
    // ------------------------------------------------------------------
    assign o_value_empty     = (r_left == '0);
    assign o_value_byte      = o_value_empty ? qkve_pkg::QKVE_CH_NUL : w_val[0];
    assign o_key_found       = r_amp || r_qry;
    assign o_from_query_form = r_qry && !r_amp;
    assign o_value_truncated = r_trunc;
    assign o_last_of_value   = w_last;

endmodule

@@ design/qkve_checker.sv @@
// Port-level checks of the query key/value extractor, bound to the top level.
module qkve_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_value_byte,
    input logic       o_key_found,
    input logic       o_from_query_form,
    input logic       o_value_empty,
    input logic       o_last_of_value
);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_value_byte) && $stable(o_last_of_value)))
        else $error("result payload changed while stalled");

    // no new input while results drain
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready)
        else $error("input accepted during emission");

    a_empty_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_value_empty) |-> (o_last_of_value && (o_value_byte == 8'h00)))
        else $error("empty result not a single zero byte");

    a_query_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_from_query_form) |-> o_key_found)
        else $error("query form flagged without a match");

    // after the last result the block goes back to scanning
    a_back_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_ready && o_last_of_value) |=> (!o_out_valid && o_in_ready))
        else $error("block did not return to scanning");

endmodule

bind query_key_value_extractor_top qkve_checker u_qkve_checker (.*);

@@ test/tb.sv @@
// Testbench for the query key/value extractor: query strings checked against a predictor.
`timescale 1ns / 1ps

module tb;
    import qkve_pkg::*;

    localparam int WIN_LEN       = QKVE_MAX_KEY + 2;  // '=' + key + prefix
    localparam int PHASE_COUNT   = 7;                 // random key settings
    localparam int PHASE_BYTES   = 46;                // random bytes per key setting
    localparam int SETTLE_CYCLES = 4;                 // idle cycles before a register write
    localparam int DRAIN_CYCLES  = 40;                // longest emission plus margin
    localparam int LONG_HOLD     = 80;                // receiver hold-off, fills the block
    localparam int QUIET_LIMIT   = 2000;              // cycles with no transaction at all
    localparam int REPORT_LIMIT  = 10;

    // One result transaction as the block presents it.
    typedef struct packed {
        logic [7:0] value_byte;
        logic       key_found;
        logic       from_query;
        logic       empty;
        logic       truncated;
        logic       last;
    } value_beat_t;

    // Scoreboard: tracks the scan state per string and holds the value bytes still owed.
    class extraction_board;
        logic [4:0]  key_len;
        logic [63:0] key_word [3];
        logic [7:0]  window [WIN_LEN];
        logic [7:0]  value_buf [QKVE_MAX_VALUE];
        int          held;
        bit          capturing;
        bit          amp_hit;
        bit          qry_hit;
        bit          cut_at_limit;
        bit          string_done;
        value_beat_t expected_beats [$];
        int          failures;
        int          beats_checked;
        int          strings_seen;
        int          found_strings;
        int          query_strings;
        int          truncated_strings;
        int          zero_ended;

        function new();
            key_len  = 5'd1;
            key_word = '{64'd0, 64'd0, 64'd0};
            clear_string();
        endfunction

        function void clear_string();
            foreach (window[i]) window[i] = 8'h00;
            held         = 0;
            capturing    = 0;
            amp_hit      = 0;
            qry_hit      = 0;
            cut_at_limit = 0;
            string_done  = 0;
        endfunction

        function void set_register(t_reg_idx idx, logic [QKVE_DATA_W-1:0] value);
            case (idx)
                REG_KEY_LENGTH: key_len     = value[4:0];
                REG_KEY_LOW:    key_word[0] = value;
                REG_KEY_MID:    key_word[1] = value;
                REG_KEY_HIGH:   key_word[2] = value;
                default: ;
            endcase
        endfunction

        function int eff_len();
            return (key_len > QKVE_MAX_KEY) ? QKVE_MAX_KEY : int'(key_len);
        endfunction

        function logic [7:0] key_char(int k);
            if (k < 8)  return key_word[0][k*8 +: 8];
            if (k < 16) return key_word[1][(k-8)*8 +: 8];
            if (k < 24) return key_word[2][(k-16)*8 +: 8];
            return 8'h00;
        endfunction

        // window[0] is the newest byte; the key reads backwards from window[len]
        function bit pattern_in_window(logic [7:0] prefix);
            int len;
            len = eff_len();
            if (window[0] != QKVE_CH_EQ) return 0;
            if (window[len+1] != prefix) return 0;
            for (int k = 0; k < len; k++)
                if (window[len-k] != key_char(k)) return 0;
            return 1;
        endfunction

        function int pending();
            return expected_beats.size();
        endfunction

        // Accepted input transaction: advance the scan, queue the value on end of string.
        function void note_byte(logic [7:0] data, logic eos);
            logic found;
            logic qform;
            if (!string_done) begin
                if (data == QKVE_CH_NUL) begin
                    string_done = 1;
                    capturing   = 0;
                    zero_ended++;
                end else begin
                    if (capturing) begin
                        if (data == QKVE_CH_AMP || data == QKVE_CH_SEMI || data == QKVE_CH_LF) begin
                            capturing = 0;
                        end else if (held >= QKVE_MAX_VALUE) begin
                            capturing    = 0;
                            cut_at_limit = 1;
                        end else begin
                            value_buf[held] = data;
                            held++;
                        end
                    end
                    for (int i = WIN_LEN - 1; i > 0; i--) window[i] = window[i-1];
                    window[0] = data;
                    if (!amp_hit && pattern_in_window(QKVE_CH_AMP)) begin
                        amp_hit      = 1;
                        capturing    = 1;
                        held         = 0;
                        cut_at_limit = 0;
                    end else if (!amp_hit && !qry_hit && pattern_in_window(QKVE_CH_QRY)) begin
                        qry_hit      = 1;
                        capturing    = 1;
                        held         = 0;
                        cut_at_limit = 0;
                    end
                end
            end
            if (eos) begin
                found = amp_hit || qry_hit;
                qform = qry_hit && !amp_hit;
                strings_seen++;
                if (found) found_strings++;
                if (qform) query_strings++;
                if (cut_at_limit) truncated_strings++;
                if (held == 0) begin
                    expected_beats.push_back('{8'h00, found, qform, 1'b1, cut_at_limit, 1'b1});
                end else begin
                    for (int k = 0; k < held; k++)
                        expected_beats.push_back('{value_buf[k], found, qform, 1'b0,
                                                   cut_at_limit, (k == held - 1)});
                end
                clear_string();
            end
        endfunction

        function string beat_text(value_beat_t v);
            return $sformatf("byte=%02h found=%0b query=%0b empty=%0b trunc=%0b last=%0b",
                             v.value_byte, v.key_found, v.from_query, v.empty,
                             v.truncated, v.last);
        endfunction

        // Accepted result transaction: compare with the oldest value byte owed.
        function void check_beat(value_beat_t got);
            value_beat_t want;
            beats_checked++;
            if (expected_beats.size() == 0) begin
                failures++;
                if (failures <= REPORT_LIMIT)
                    $display("[%0t] unexpected result: %s", $time, beat_text(got));
                return;
            end
            want = expected_beats.pop_front();
            if (got.value_byte !== want.value_byte || got.key_found !== want.key_found ||
                got.from_query !== want.from_query || got.empty !== want.empty ||
                got.truncated !== want.truncated || got.last !== want.last) begin
                failures++;
                if (failures <= REPORT_LIMIT) begin
                    $display("[%0t] result mismatch", $time);
                    $display("    expected %s", beat_text(want));
                    $display("    actual   %s", beat_text(got));
                end
            end
        endfunction
    endclass

    // ---------------------------------------------------------------------------------------
    // DUT signals
    // ---------------------------------------------------------------------------------------
    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [7:0]             i_data_byte;
    logic                   i_end_of_string;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [7:0]             o_value_byte;
    logic                   o_key_found;
    logic                   o_from_query_form;
    logic                   o_value_empty;
    logic                   o_value_truncated;
    logic                   o_last_of_value;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [QKVE_ADDR_W-1:0] paddr;
    logic [QKVE_DATA_W-1:0] pwdata;
    logic [QKVE_DATA_W-1:0] prdata;
    logic                   pready;

    extraction_board extraction;

    // String under construction, one entry per input transaction.
    logic [7:0] text_q [$];

    // Idling controls, switched per phase by the stimulus.
    bit tx_idle_on    = 0;
    bit rx_idle_on    = 0;
    bit long_hold_req = 0;

    int bytes_sent   = 0;
    int strings_sent = 0;
    int key_sets     = 0;
    int quiet_cycles = 0;

    query_key_value_extractor_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_end_of_string   (i_end_of_string),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_value_byte      (o_value_byte),
        .o_key_found       (o_key_found),
        .o_from_query_form (o_from_query_form),
        .o_value_empty     (o_value_empty),
        .o_value_truncated (o_value_truncated),
        .o_last_of_value   (o_last_of_value),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------------------------------
    // Result side: ready with random stall bursts; a long hold-off on request.
    // The long hold is counted here so the sender keeps offering bytes meanwhile,
    // which backs the block up until it drops o_in_ready.
    // ---------------------------------------------------------------------------------------
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = LONG_HOLD;
            end else if (stall_left == 0 && rx_idle_on && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 10);
            end
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Sample at the edge: values seen here are the ones the edge accepts.
    always @(posedge i_clk) begin : result_monitor
        value_beat_t seen;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_ready === 1'b1) begin
            seen = '{o_value_byte, o_key_found, o_from_query_form, o_value_empty,
                     o_value_truncated, o_last_of_value};
            extraction.check_beat(seen);
        end
    end

    // Watchdog: any transaction on either channel or the register port restarts the count.
    always @(posedge i_clk) begin
        if ((i_in_valid === 1'b1 && o_in_ready === 1'b1) ||
            (o_out_valid === 1'b1 && i_out_ready === 1'b1) || psel) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[%0t] no transaction for %0d cycles, %0d results still owed",
                     $time, QUIET_LIMIT, extraction.pending());
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ---------------------------------------------------------------------------------------
    // Drivers
    // ---------------------------------------------------------------------------------------

    // Register write: setup cycle, then access cycle; the edge with pready high commits it.
    task automatic write_reg(input t_reg_idx idx, input logic [QKVE_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        extraction.set_register(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drop valid and sit until every owed result has been taken.
    task automatic wait_all_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (extraction.pending() != 0);
    endtask

    // New key setting, written only while the block is idle.
    task automatic change_key(input logic [4:0] len, input logic [63:0] low,
                              input logic [63:0] mid, input logic [63:0] high);
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        write_reg(REG_KEY_LENGTH, {59'd0, len});
        write_reg(REG_KEY_LOW, low);
        write_reg(REG_KEY_MID, mid);
        write_reg(REG_KEY_HIGH, high);
        key_sets++;
    endtask

    // One input transaction, with an occasional random gap in front of it.
    task automatic send_byte(input logic [7:0] data, input logic last);
        if (tx_idle_on && $urandom_range(0, 7) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_data_byte     <= data;
        i_end_of_string <= last;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        extraction.note_byte(data, last);
        bytes_sent++;
    endtask

    // Send text_q as one string; the last byte carries end of string.
    task automatic send_text();
        foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
        strings_sent++;
    endtask

    function automatic void load_text(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
    endfunction

    // ---------------------------------------------------------------------------------------
    // Random string content
    // ---------------------------------------------------------------------------------------
    function automatic logic [63:0] letter_word();
        logic [63:0] w;
        for (int i = 0; i < 8; i++) w[i*8 +: 8] = 8'($urandom_range(97, 122));
        return w;
    endfunction

    // Junk between patterns: letters most often, some delimiters, key characters and random bytes, rare zero bytes.
    function automatic logic [7:0] filler_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 8'($urandom_range(97, 122));
        if (r < 60) begin
            case ($urandom_range(0, 4))
                0: return QKVE_CH_AMP;
                1: return QKVE_CH_QRY;
                2: return QKVE_CH_EQ;
                3: return QKVE_CH_SEMI;
                default: return QKVE_CH_LF;
            endcase
        end
        if (r < 62) return QKVE_CH_NUL;
        if (r < 72) return extraction.key_char($urandom_range(0, QKVE_KEY_SLOTS - 1));
        return 8'($urandom_range(1, 255));
    endfunction

    // Value characters; the printable range includes ';' so some values end early.
    function automatic logic [7:0] value_char();
        if ($urandom_range(0, 99) < 80) return 8'($urandom_range(48, 122));
        return 8'($urandom_range(1, 255));
    endfunction

    // prefix + key + '=' + value + optional terminator, or a prefix + partial key + filler byte.
    function automatic void add_pattern(input logic [7:0] prefix, input bit broken);
        int klen;
        int cut;
        int vlen;
        int r;
        klen = extraction.eff_len();
        text_q.push_back(prefix);
        if (broken) begin
            cut = (klen > 0) ? $urandom_range(0, klen - 1) : 0;
            for (int k = 0; k < cut; k++) text_q.push_back(extraction.key_char(k));
            text_q.push_back(filler_byte());
            return;
        end
        for (int k = 0; k < klen; k++) text_q.push_back(extraction.key_char(k));
        text_q.push_back(QKVE_CH_EQ);
        r = $urandom_range(0, 99);
        if (r < 65)      vlen = $urandom_range(0, 6);
        else if (r < 85) vlen = $urandom_range(7, 20);
        else             vlen = $urandom_range(QKVE_MAX_VALUE - 1, QKVE_MAX_VALUE + 2);
        repeat (vlen) text_q.push_back(value_char());
        r = $urandom_range(0, 99);
        if (r < 15)      text_q.push_back(QKVE_CH_AMP);
        else if (r < 27) text_q.push_back(QKVE_CH_SEMI);
        else if (r < 39) text_q.push_back(QKVE_CH_LF);
        else if (r < 45) text_q.push_back(QKVE_CH_NUL);
        else if (r < 55) text_q.push_back(filler_byte());
    endfunction

    // Mostly well-formed query strings with random content, some pure noise.
    function automatic void build_random_text();
        int parts;
        int r;
        logic [7:0] prefix;
        text_q.delete();
        if ($urandom_range(0, 99) < 15) begin
            repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
            return;
        end
        parts = $urandom_range(1, 3);
        for (int p = 0; p < parts; p++) begin
            r      = $urandom_range(0, 99);
            prefix = ($urandom_range(0, 9) < 6) ? QKVE_CH_AMP : QKVE_CH_QRY;
            if (r < 55)      add_pattern(prefix, 1'b0);
            else if (r < 70) add_pattern(prefix, 1'b1);
            else             repeat ($urandom_range(1, 5)) text_q.push_back(filler_byte());
        end
    endfunction

    // ---------------------------------------------------------------------------------------
    // Main sequence: reset, directed strings, random phases over several key settings, drain.
    // ---------------------------------------------------------------------------------------
    initial begin : stimulus
        int phase_start;
        int n;
        logic [63:0] w;

        extraction      = new();
        i_rst_n         <= 1'b0;
        i_in_valid      <= 1'b0;
        i_data_byte     <= 8'h00;
        i_end_of_string <= 1'b0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-character key "k".
        change_key(5'd1, {56'd0, "k"}, 64'd0, 64'd0);
        load_text("&k=ab");           // plain amp match, two value bytes
        send_text();
        load_text("?k=x&k=y");        // query-form capture replaced by a later amp match
        send_text();
        load_text("?k=");             // match on the last byte: empty value, query form
        send_text();
        text_q = '{8'hFF};            // one-byte string, all ones, nothing found
        send_text();
        load_text("&k=q");            // zero byte ends the string, trailing byte ignored
        text_q.push_back(QKVE_CH_NUL);
        text_q.push_back("r");
        send_text();

        // Directed: zero key length, the pattern collapses to "&=".
        change_key(5'd0, 64'd0, 64'd0, 64'd0);
        load_text("&=v");
        send_text();

        // Random phases. The last one runs with no idling on either side.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph)
                0: change_key(5'd3, letter_word(), letter_word(), letter_word());
                1: change_key(5'd24, letter_word(), letter_word(), letter_word());
                // over-long length clamps to the full key; key of all ones
                2: change_key(5'd31, '1, '1, '1);
                3: change_key(5'd1, {$urandom, $urandom}, {$urandom, $urandom},
                              {$urandom, $urandom});
                // zero byte inside the key: never matches
                4: begin
                    w        = letter_word();
                    w[23:16] = QKVE_CH_NUL;
                    change_key(5'd5, w, 64'd0, 64'd0);
                end
                5: change_key(5'd0, letter_word(), letter_word(), letter_word());
                default: change_key(5'($urandom_range(1, 8)), letter_word(), letter_word(),
                                    letter_word());
            endcase
            tx_idle_on  = (ph != PHASE_COUNT - 1) && (ph != 1);
            rx_idle_on  = (ph != PHASE_COUNT - 1) && (ph != 4);
            phase_start = bytes_sent;
            n           = 0;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                // back-pressure: receiver holds off while the sender keeps going
                if ((ph == 0 || ph == 3) && n == 1) long_hold_req = 1'b1;
                // sender pause until every owed result is out
                if (ph == 2 && n == 2) wait_all_results();
                build_random_text();
                send_text();
                n++;
            end
        end

        wait_all_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d strings (%0d bytes) under %0d key settings; %0d results checked.",
                 strings_sent, bytes_sent, key_sets, extraction.beats_checked);
        $display("Key found in %0d strings, %0d by query form; %0d truncated; %0d cut by zero.",
                 extraction.found_strings, extraction.query_strings,
                 extraction.truncated_strings, extraction.zero_ended);
        if (extraction.failures == 0 && extraction.pending() == 0) begin
            $display("Simulation PASSED");
        end else begin
            if (extraction.pending() != 0)
                $display("%0d expected results never arrived", extraction.pending());
            $display("%0d mismatches", extraction.failures);
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
